// ===== sv/spoken_word_segment_detector_macros.svh =====
// Assertion helpers; clocked on clk_i, off while rst_ni is low.
`ifndef SPOKEN_WORD_SEGMENT_DETECTOR_MACROS_SVH
`define SPOKEN_WORD_SEGMENT_DETECTOR_MACROS_SVH

`define SWSD_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) else $error(msg);

`define SWSD_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) else $error(msg);

`endif

// ===== sv/swsd_pkg.sv =====
package swsd_pkg;

  localparam int SAMPLE_BITS          = 16;
  localparam int MAX_INTERVAL_SAMPLES = 1048576;
  localparam int MAX_FRAGMENT_SAMPLES = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int BYTE_W     = 23;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 21;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WORD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SYLLABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BPS      = 3'd7;

  localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] byte_offset;
    logic [BYTE_W-1:0] byte_size;
    logic              last;
  } out_item_t;

endpackage

// ===== sv/swsd_in_if.sv =====
interface swsd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [swsd_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   new_run;

  modport source(output valid, sample, new_run, input ready);
  modport sink(input valid, sample, new_run, output ready);
endinterface

// ===== sv/swsd_out_if.sv =====
interface swsd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [swsd_pkg::BYTE_W-1:0]   byte_offset;
  logic [swsd_pkg::BYTE_W-1:0]   byte_size;
  logic                          last;

  modport source(output valid, kind, byte_offset, byte_size, last, input ready);
  modport sink(input valid, kind, byte_offset, byte_size, last, output ready);
endinterface

// ===== sv/spoken_word_segment_detector.sv =====
// Spoken word segment detector. Takes one signed sample per request and reports
// word segments (kind 0) and, at the end of each interval, the strongest word
// (kind 1) as byte offset and size. A sample in the interval runs through check,
// fragment (when it closes one) and tail states before the next ready. Gap-closed
// words add the gap, compare and byte-scaling states, words open at the interval
// end compare and scale, and the strongest word only scales. All of these use one
// shared 25x21 multiplier, one product per cycle: gap and syllable lengths, the
// exact mean-energy cross-multiplication (four partial products) and the byte
// scaling. Results go through a two-entry output queue, and the block also waits
// while that queue is full. Registers may be written only while idle.
`include "spoken_word_segment_detector_macros.svh"

module spoken_word_segment_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swsd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  swsd_in_if.sink                             in_i,
  swsd_out_if.source                          out_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CHECK = 5'd1;
  localparam logic [4:0] ST_FRAG  = 5'd2;
  localparam logic [4:0] ST_GAP0  = 5'd3;
  localparam logic [4:0] ST_GAP1  = 5'd4;
  localparam logic [4:0] ST_GAP2  = 5'd5;
  localparam logic [4:0] ST_TAIL  = 5'd6;
  localparam logic [4:0] ST_FINAL = 5'd7;
  localparam logic [4:0] ST_C0    = 5'd8;
  localparam logic [4:0] ST_C1    = 5'd9;
  localparam logic [4:0] ST_C2    = 5'd10;
  localparam logic [4:0] ST_C3    = 5'd11;
  localparam logic [4:0] ST_C4    = 5'd12;
  localparam logic [4:0] ST_B0    = 5'd13;
  localparam logic [4:0] ST_B1    = 5'd14;
  localparam logic [4:0] ST_B2    = 5'd15;
  localparam logic [4:0] ST_PUSH  = 5'd16;

  localparam logic [20:0] INTERVAL_MAX = 21'(swsd_pkg::MAX_INTERVAL_SAMPLES);
  localparam logic [12:0] FRAG_MAX     = 13'(swsd_pkg::MAX_FRAGMENT_SAMPLES);
  localparam logic [20:0] COUNT_MAX    = 21'h1FFFFF;
  localparam logic [9:0]  SILENT_MAX   = 10'd1023;

  // configuration
  logic [15:0] noise_q;
  logic [12:0] frag_q;
  logic [20:0] lead_q;
  logic [9:0]  minw_q, gap_q, syl_q;
  logic [20:0] interval_q;
  logic [2:0]  bps_q;

  // run state
  logic [4:0]  state_q, ret_q;
  logic signed [swsd_pkg::SAMPLE_BITS-1:0] smp_q;
  logic [20:0] sidx_q;
  logic [27:0] fe_q;
  logic [12:0] fill_q;
  logic [35:0] we_q, be_q;
  logic [20:0] wc_q, bc_q;
  logic [9:0]  silent_q;
  logic [20:0] ws_q, bstart_q, isn_q;
  logic [24:0] blen_q;

  // emission
  logic [20:0] seg_start_q;
  logic [24:0] seg_len_q;
  logic        kind_q, last_q;
  logic [56:0] acc_a_q, acc_b_q;
  logic [22:0] off_q, size_q;

  logic [20:0] interval_c;
  logic [12:0] fs_c;
  logic [9:0]  minw_c;
  logic [16:0] mag;
  logic [27:0] fe_n;
  logic [12:0] fill_n;
  logic [9:0]  silent_n;
  logic [20:0] sn;
  logic signed [25:0] t_ws, t_isn, t_diff, t_syl, t_end, t_len, t_tail;
  logic [20:0] ws_n, isn_n;
  logic [24:0] len_gap, len_tail;
  logic        gap_last;
  logic [22:0] sat_prod;
  logic [swsd_pkg::MUL_A_W-1:0] mul_a;
  logic [swsd_pkg::MUL_B_W-1:0] mul_b;
  logic [swsd_pkg::PROD_W-1:0]  prod;
  logic        push, full;
  logic [1:0]  fifo_count;
  swsd_pkg::out_item_t item;
  logic        accept, better;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    interval_c = (interval_q > INTERVAL_MAX) ? INTERVAL_MAX : interval_q;
    fs_c       = (frag_q == 13'd0) ? 13'd1 : ((frag_q > FRAG_MAX) ? FRAG_MAX : frag_q);
    minw_c     = (minw_q == 10'd0) ? 10'd1 : minw_q;

    mag    = smp_q[swsd_pkg::SAMPLE_BITS-1] ? (17'd0 - 17'(smp_q)) : 17'(smp_q);
    fe_n   = (mag > {1'b0, noise_q}) ? fe_q + 28'(mag) : fe_q;
    fill_n = fill_q + 13'd1;
    silent_n = (silent_q < SILENT_MAX) ? silent_q + 10'd1 : silent_q;

    sn = (ws_q >= lead_q) ? ws_q - lead_q : 21'd0;

    t_ws = $signed({5'b0, sidx_q}) + 26'sd1 - $signed({13'b0, fs_c});
    ws_n = (t_ws < 0) ? 21'd0 : t_ws[20:0];

    t_isn = $signed({5'b0, sidx_q}) + 26'sd1 - $signed({3'b0, prod[22:0]});
    isn_n = (t_isn < 0) ? 21'd0 : t_isn[20:0];

    t_syl  = $signed({3'b0, prod[22:0]});
    t_diff = $signed({5'b0, isn_q}) - $signed({5'b0, ws_q});
    t_end  = (t_diff >= t_syl) ? $signed({5'b0, isn_q}) - 26'sd1
                               : $signed({5'b0, ws_q}) + t_syl - 26'sd1;
    t_len  = t_end - $signed({5'b0, sn}) + 26'sd1;
    len_gap = (t_len < 0) ? 25'd0 : t_len[24:0];

    t_tail   = $signed({5'b0, interval_c}) - $signed({5'b0, sn});
    len_tail = (t_tail < 0) ? 25'd0 : t_tail[24:0];

    gap_last = ({1'b0, sidx_q} + 22'd1) < {1'b0, interval_c};
    sat_prod = (prod > swsd_pkg::PROD_W'(swsd_pkg::BYTE_MAX)) ? swsd_pkg::BYTE_MAX
                                                             : prod[22:0];
    better   = acc_a_q > (acc_b_q + {prod[38:0], 18'b0});
  end

  always_comb begin
    unique case (state_q)
      ST_GAP0: begin
        mul_a = 25'(silent_q);
        mul_b = 21'(fs_c);
      end
      ST_GAP1: begin
        mul_a = 25'(syl_q);
        mul_b = 21'(fs_c);
      end
      ST_C0: begin
        mul_a = 25'(we_q[17:0]);
        mul_b = bc_q;
      end
      ST_C1: begin
        mul_a = 25'(we_q[35:18]);
        mul_b = bc_q;
      end
      ST_C2: begin
        mul_a = 25'(be_q[17:0]);
        mul_b = wc_q;
      end
      ST_C3: begin
        mul_a = 25'(be_q[35:18]);
        mul_b = wc_q;
      end
      ST_B0: begin
        mul_a = 25'(seg_start_q);
        mul_b = 21'(bps_q);
      end
      ST_B1: begin
        mul_a = seg_len_q;
        mul_b = 21'(bps_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  swsd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign push = (state_q == ST_PUSH) && !full;
  always_comb begin
    item.kind        = kind_q;
    item.byte_offset = off_q;
    item.byte_size   = size_q;
    item.last        = last_q;
  end

  swsd_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .full_o  (full),
    .count_o (fifo_count),
    .out_o   (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q    <= 16'd0;
      frag_q     <= 13'd160;
      lead_q     <= 21'd0;
      minw_q     <= 10'd1;
      gap_q      <= 10'd1;
      syl_q      <= 10'd0;
      interval_q <= 21'd16000;
      bps_q      <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swsd_pkg::REG_NOISE:    noise_q    <= cfg_wdata_i[15:0];
        swsd_pkg::REG_FRAG:     frag_q     <= cfg_wdata_i[12:0];
        swsd_pkg::REG_LEAD:     lead_q     <= cfg_wdata_i;
        swsd_pkg::REG_MIN_WORD: minw_q     <= cfg_wdata_i[9:0];
        swsd_pkg::REG_GAP:      gap_q      <= cfg_wdata_i[9:0];
        swsd_pkg::REG_SYLLABLE: syl_q      <= cfg_wdata_i[9:0];
        swsd_pkg::REG_INTERVAL: interval_q <= cfg_wdata_i;
        swsd_pkg::REG_BPS:      bps_q      <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      sidx_q   <= '0;
      fe_q     <= '0;
      fill_q   <= '0;
      we_q     <= '0;
      wc_q     <= '0;
      silent_q <= '0;
      ws_q     <= '0;
      be_q     <= '0;
      bc_q     <= 21'd1;
      bstart_q <= '0;
      blen_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_i.new_run) begin
              sidx_q   <= '0;
              fe_q     <= '0;
              fill_q   <= '0;
              we_q     <= '0;
              wc_q     <= '0;
              silent_q <= '0;
              ws_q     <= '0;
              be_q     <= '0;
              bc_q     <= 21'd1;
              bstart_q <= '0;
              blen_q   <= '0;
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sidx_q >= interval_c) begin
            state_q <= ST_IDLE;
          end else if (fill_n >= fs_c) begin
            fe_q    <= fe_n;
            state_q <= ST_FRAG;
          end else begin
            fe_q    <= fe_n;
            fill_q  <= fill_n;
            state_q <= ST_TAIL;
          end
        end
        ST_FRAG: begin
          fill_q <= '0;
          fe_q   <= '0;
          state_q <= ST_TAIL;
          if (fe_q != 28'd0) begin
            if (wc_q == 21'd0) begin
              ws_q <= ws_n;
              we_q <= 36'(fe_q);
            end else begin
              we_q <= we_q + 36'(fe_q);
            end
            if (wc_q < COUNT_MAX) wc_q <= wc_q + 21'd1;
            silent_q <= '0;
          end else begin
            silent_q <= silent_n;
            if (silent_n >= gap_q) begin
              if (wc_q >= 21'(minw_c)) begin
                state_q <= ST_GAP0;
              end else begin
                wc_q <= '0;
              end
            end
          end
        end
        ST_GAP0: state_q <= ST_GAP1;
        ST_GAP1: begin
          isn_q   <= isn_n;
          state_q <= ST_GAP2;
        end
        ST_GAP2: begin
          seg_start_q <= sn;
          seg_len_q   <= len_gap;
          kind_q      <= 1'b0;
          last_q      <= gap_last;
          ret_q       <= ST_TAIL;
          state_q     <= ST_C0;
        end
        ST_TAIL: begin
          sidx_q <= sidx_q + 21'd1;
          if ((sidx_q + 21'd1) >= interval_c) begin
            if (wc_q >= 21'(minw_c)) begin
              seg_start_q <= sn;
              seg_len_q   <= len_tail;
              kind_q      <= 1'b0;
              last_q      <= 1'b0;
              ret_q       <= ST_FINAL;
              state_q     <= ST_C0;
            end else begin
              state_q <= ST_FINAL;
            end
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_FINAL: begin
          seg_start_q <= bstart_q;
          seg_len_q   <= blen_q;
          kind_q      <= 1'b1;
          last_q      <= 1'b1;
          ret_q       <= ST_IDLE;
          state_q     <= ST_B0;
        end
        ST_C0: state_q <= ST_C1;
        ST_C1: begin
          acc_a_q <= 57'(prod[38:0]);
          state_q <= ST_C2;
        end
        ST_C2: begin
          acc_a_q <= acc_a_q + {prod[38:0], 18'b0};
          state_q <= ST_C3;
        end
        ST_C3: begin
          acc_b_q <= 57'(prod[38:0]);
          state_q <= ST_C4;
        end
        ST_C4: begin
          if (better) begin
            be_q     <= we_q;
            bc_q     <= wc_q;
            bstart_q <= seg_start_q;
            blen_q   <= seg_len_q;
          end
          if (ret_q == ST_TAIL) wc_q <= '0;
          state_q <= ST_B0;
        end
        ST_B0: state_q <= ST_B1;
        ST_B1: begin
          off_q   <= sat_prod;
          state_q <= ST_B2;
        end
        ST_B2: begin
          size_q  <= sat_prod;
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!full) state_q <= ret_q;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) smp_q <= in_i.sample;
  end

  `SWSD_ASSERT_SAME(a_push_room, push, fifo_count != 2'd2, "push into a full output queue")
  `SWSD_ASSERT_NEXT(a_busy_after_req, accept, !in_i.ready, "request taken while still busy")
  `SWSD_ASSERT_SAME(a_final_last, out_o.valid && out_o.kind, out_o.last, "strongest word not last")
  `SWSD_ASSERT_SAME(a_best_count, state_q == ST_C0, bc_q != 21'd0, "zero best fragment count")

endmodule

// ===== sv/swsd_mul.sv =====
module swsd_mul (
  input  logic                            clk_i,
  input  logic [swsd_pkg::MUL_A_W-1:0]    a_i,
  input  logic [swsd_pkg::MUL_B_W-1:0]    b_i,
  output logic [swsd_pkg::PROD_W-1:0]     prod_o
);

  logic [swsd_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= swsd_pkg::PROD_W'(a_i) * swsd_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/swsd_ofifo.sv =====
module swsd_ofifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  swsd_pkg::out_item_t   item_i,
  output logic                  full_o,
  output logic [1:0]            count_o,
  swsd_out_if.source            out_o
);

  swsd_pkg::out_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign full_o            = (count_q == 2'd2);
  assign count_o           = count_q;
  assign out_o.valid       = (count_q != 2'd0);
  assign out_o.kind        = mem_q[rd_q].kind;
  assign out_o.byte_offset = mem_q[rd_q].byte_offset;
  assign out_o.byte_size   = mem_q[rd_q].byte_size;
  assign out_o.last        = mem_q[rd_q].last;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

class segment_scoreboard;
  int unsigned noise, frag, lead, minw, gap, syl, interval, bps;
  longint pos, fill, wstart, bstart, blen;
  longint unsigned fen, wen, ben;
  int unsigned wcnt, scnt, bcnt;
  swsd_pkg::out_item_t segment_q[$];
  int errors, checked, words, finals;

  function new();
    noise = 0; frag = 160; lead = 0; minw = 1; gap = 1; syl = 0;
    interval = 16000; bps = 2;
    clear_run();
  endfunction

  function void clear_run();
    pos = 0; fill = 0; fen = 0; wen = 0; wcnt = 0; scnt = 0; wstart = 0;
    ben = 0; bcnt = 1; bstart = 0; blen = 0;
  endfunction

  function void set_reg(logic [swsd_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    case (idx)
      swsd_pkg::REG_NOISE: noise = v & 32'hFFFF;
      swsd_pkg::REG_FRAG: frag = v & 32'h1FFF;
      swsd_pkg::REG_LEAD: lead = v & 32'h1FFFFF;
      swsd_pkg::REG_MIN_WORD: minw = v & 32'h3FF;
      swsd_pkg::REG_GAP: gap = v & 32'h3FF;
      swsd_pkg::REG_SYLLABLE: syl = v & 32'h3FF;
      swsd_pkg::REG_INTERVAL: interval = v & 32'h1FFFFF;
      default: bps = v & 32'h7;
    endcase
  endfunction

  function longint to_bytes(longint s);
    longint b;
    if (s <= 0) return 0;
    b = s * longint'(bps);
    return (b > 64'd8388607) ? 64'd8388607 : b;
  endfunction

  function void add_segment(bit k, longint s, longint l);
    swsd_pkg::out_item_t it;
    it.kind = k;
    it.byte_offset = swsd_pkg::BYTE_W'(to_bytes(s));
    it.byte_size = swsd_pkg::BYTE_W'(to_bytes(l));
    it.last = 1'b0;
    segment_q = {segment_q, it};
  endfunction

  function longint padded_start();
    return (wstart >= longint'(lead)) ? wstart - longint'(lead) : 0;
  endfunction

  function void weigh_word(longint s, longint l);
    if (wen * longint'(bcnt) > ben * longint'(wcnt)) begin
      ben = wen; bcnt = wcnt; bstart = s; blen = l;
    end
  endfunction

  function bit note_request(logic signed [swsd_pkg::SAMPLE_BITS-1:0] smp, bit nr);
    longint iv, fs, mw, mag, isn, sylv, endp, sn, len, st;
    int first;
    first = segment_q.size();
    if (nr) clear_run();
    iv = (interval > swsd_pkg::MAX_INTERVAL_SAMPLES) ? swsd_pkg::MAX_INTERVAL_SAMPLES : interval;
    if (pos >= iv) return 0;
    fs = (frag < 1) ? 1 : ((frag > swsd_pkg::MAX_FRAGMENT_SAMPLES) ?
         swsd_pkg::MAX_FRAGMENT_SAMPLES : frag);
    mw = (minw < 1) ? 1 : minw;
    mag = smp;
    if (mag < 0) mag = -mag;
    if (mag > longint'(noise)) fen += mag;
    fill++;
    if (fill >= fs) begin
      fill = 0;
      if (fen != 0) begin
        if (wcnt == 0) begin
          st = pos + 1 - fs;
          wstart = (st < 0) ? 0 : st;
          wen = fen;
        end else begin
          wen += fen;
        end
        if (wcnt < 2097151) wcnt++;
        scnt = 0;
      end else begin
        if (scnt < 1023) scnt++;
        if (scnt >= gap) begin
          if (longint'(wcnt) >= mw) begin
            isn = pos + 1 - longint'(scnt) * fs;
            sylv = longint'(syl) * fs;
            if (isn < 0) isn = 0;
            endp = (isn - wstart >= sylv) ? isn - 1 : wstart + sylv - 1;
            sn = padded_start();
            len = endp - sn + 1;
            if (len < 0) len = 0;
            weigh_word(sn, len);
            add_segment(1'b0, sn, len);
            words++;
          end
          wcnt = 0;
        end
      end
      fen = 0;
    end
    pos++;
    if (pos >= iv) begin
      if (longint'(wcnt) >= mw) begin
        sn = padded_start();
        len = iv - sn;
        if (len < 0) len = 0;
        weigh_word(sn, len);
        add_segment(1'b0, sn, len);
        words++;
      end
      add_segment(1'b1, bstart, blen);
      finals++;
    end
    if (segment_q.size() > first) segment_q[$].last = 1'b1;
    return 1;
  endfunction

  function void check_result(swsd_pkg::out_item_t got);
    swsd_pkg::out_item_t exp;
    if (segment_q.size() == 0) begin
      $display("%0t: unexpected result kind=%0d off=%0d size=%0d last=%0d", $time,
               got.kind, got.byte_offset, got.byte_size, got.last);
      errors++;
      return;
    end
    exp = segment_q.pop_front();
    checked++;
    if (got.kind !== exp.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
      errors++;
    end
    if (got.byte_offset !== exp.byte_offset) begin
      $display("%0t: byte_offset expected %0d actual %0d", $time, exp.byte_offset,
               got.byte_offset);
      errors++;
    end
    if (got.byte_size !== exp.byte_size) begin
      $display("%0t: byte_size expected %0d actual %0d", $time, exp.byte_size,
               got.byte_size);
      errors++;
    end
    if (got.last !== exp.last) begin
      $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [swsd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [swsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  swsd_in_if in_bus();
  swsd_out_if out_bus();

  spoken_word_segment_detector DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_bus),
    .out_o(out_bus)
  );

  segment_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int rand_count;
  bit rand_part;
  bit stall_kick;
  int stall_left;
  bit stall_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_kick && !stall_done) begin
      out_bus.ready <= 1'b0;
      stall_left <= 400;
      stall_done <= 1'b1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    swsd_pkg::out_item_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.kind = out_bus.kind;
      got.byte_offset = out_bus.byte_offset;
      got.byte_size = out_bus.byte_size;
      got.last = out_bus.last;
      sb.check_result(got);
    end
  end

  task automatic write_reg(logic [swsd_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= swsd_pkg::CFG_DATA_W'(v);
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(int unsigned nl, int unsigned fr, int unsigned ld,
                           int unsigned mw, int unsigned gp, int unsigned sy,
                           int unsigned iv, int unsigned bp);
    write_reg(swsd_pkg::REG_NOISE, nl);
    write_reg(swsd_pkg::REG_FRAG, fr);
    write_reg(swsd_pkg::REG_LEAD, ld);
    write_reg(swsd_pkg::REG_MIN_WORD, mw);
    write_reg(swsd_pkg::REG_GAP, gp);
    write_reg(swsd_pkg::REG_SYLLABLE, sy);
    write_reg(swsd_pkg::REG_INTERVAL, iv);
    write_reg(swsd_pkg::REG_BPS, bp);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [swsd_pkg::SAMPLE_BITS-1:0] s, bit nr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample <= s;
    in_bus.new_run <= nr;
    do @(posedge clk_i); while (!in_bus.ready);
    if (sb.note_request(s, nr) && rand_part) rand_count++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.segment_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [swsd_pkg::SAMPLE_BITS-1:0] loud_sample(int unsigned nl);
    int m;
    m = (nl >= 32768) ? 32768 : $urandom_range(32768, nl + 1);
    if ($urandom_range(1) || m == 32768) return swsd_pkg::SAMPLE_BITS'(-m);
    return swsd_pkg::SAMPLE_BITS'(m);
  endfunction

  function automatic logic signed [swsd_pkg::SAMPLE_BITS-1:0] quiet_sample(int unsigned nl);
    int m;
    m = $urandom_range((nl > 32767) ? 32767 : nl, 0);
    return $urandom_range(1) ? swsd_pkg::SAMPLE_BITS'(-m) : swsd_pkg::SAMPLE_BITS'(m);
  endfunction

  task automatic run_random_phase();
    int unsigned fr, fe, iv, nl, n, k, r, len;
    fr = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
    fe = (fr == 0) ? 1 : fr;
    iv = fe * $urandom_range(40, 6);
    nl = ($urandom_range(3) == 0) ? 0 : $urandom_range(300, 0);
    configure(nl, fr, $urandom_range(30, 0), $urandom_range(3, 0), $urandom_range(4, 0),
              $urandom_range(5, 0), iv,
              ($urandom_range(7) == 0) ? $urandom_range(7, 0) : $urandom_range(4, 1));
    n = iv + $urandom_range(4, 0);
    k = 0;
    if ($urandom_range(3) != 0) begin
      send_sample(loud_sample(nl), 1'b1);
      k++;
    end
    while (k < n) begin
      if (rand_count > 600) stall_kick = 1'b1;
      send_idle_pct = (rand_count < 400) ? 22 : (rand_count < 800) ? 53 : 0;
      recv_idle_pct = (rand_count < 400) ? 53 : (rand_count < 800) ? 22 : 0;
      r = $urandom_range(99);
      if (r < 2) begin
        send_sample(swsd_pkg::SAMPLE_BITS'($urandom), 1'b1);
        k++;
      end else if (r < 10) begin
        send_sample(swsd_pkg::SAMPLE_BITS'($urandom), 1'b0);
        k++;
      end else if (r < 55) begin
        len = fe * $urandom_range(5, 1);
        repeat (len) begin
          send_sample(($urandom_range(4) == 0) ? quiet_sample(nl) : loud_sample(nl), 1'b0);
        end
        k += len;
      end else begin
        len = fe * $urandom_range(6, 1);
        repeat (len) send_sample(quiet_sample(nl), 1'b0);
        k += len;
      end
    end
    drain();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 22;
    recv_idle_pct = 53;
    rand_count = 0;
    rand_part = 1'b0;
    stall_kick = 1'b0;
    stall_left = 0;
    stall_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.new_run = 1'b0;
    out_bus.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(100, 2, 3, 1, 1, 2, 24, 2);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd101, 1'b0);
    send_sample(-16'sd101, 1'b0);
    repeat (6) send_sample(16'sd0, 1'b0);
    send_sample(16'sd5000, 1'b0);
    repeat (10) send_sample(16'sd0, 1'b0);
    send_sample(16'sd7, 1'b0);
    drain();

    configure(0, 0, 0, 0, 0, 0, 0, 0);
    send_sample(16'sd1234, 1'b1);
    send_sample(-16'sd1234, 1'b0);
    drain();

    configure(65535, 8191, 2097151, 1023, 1023, 1023, 2097151, 7);
    repeat (4) send_sample(swsd_pkg::SAMPLE_BITS'($urandom), 1'b1);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(0, 128, 0, 1, 1, 1023, 300, 4);
    send_sample(16'sd300, 1'b1);
    repeat (127) send_sample(loud_sample(0), 1'b0);
    repeat (172) send_sample(16'sd0, 1'b0);
    drain();

    configure(40, 1, 2, 1, 1023, 3, 200, 3);
    send_sample(16'sd41, 1'b1);
    repeat (4) send_sample(loud_sample(40), 1'b0);
    repeat (195) send_sample(quiet_sample(40), 1'b0);
    drain();

    rand_part = 1'b1;
    while (rand_count < 1250) run_random_phase();

    $display("Covered %0d words and %0d interval ends over %0d random samples.",
             sb.words, sb.finals, rand_count);
    $display("Checked %0d results, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.segment_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/swsd_pkg.sv
sv/swsd_in_if.sv
sv/swsd_out_if.sv
sv/swsd_mul.sv
sv/swsd_ofifo.sv
sv/spoken_word_segment_detector.sv
tb/sv/tb_top.sv
